// File: src/sha1sh_pkg.sv
// ============================================================================
// sha1sh_pkg
// Shared types and constants for the SHA-1 stream hasher.
// ============================================================================
`default_nettype none

package sha1sh_pkg;

    localparam int unsigned WordW      = 32;
    localparam int unsigned NumWords   = 5;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned BlockBits  = BlockBytes * 8;
    localparam int unsigned FillW      = $clog2(BlockBytes);
    localparam int unsigned MsgW       = 29;
    localparam int unsigned RoundW     = 7;
    localparam int unsigned IdxW       = 3;
    localparam int unsigned LenW       = 3;

    typedef logic [WordW-1:0]  word_t;
    typedef logic [RoundW-1:0] round_t;

    localparam word_t K0 = 32'h5A82_7999;
    localparam word_t K1 = 32'h6ED9_EBA1;
    localparam word_t K2 = 32'h8F1B_BCDC;
    localparam word_t K3 = 32'hCA62_C1D6;

    localparam word_t INIT_CHAIN [NumWords] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam round_t ROUND_F1   = 7'd20;
    localparam round_t ROUND_F2   = 7'd40;
    localparam round_t ROUND_F3   = 7'd60;
    localparam round_t LAST_ROUND = 7'd79;

    localparam logic [FillW-1:0] FILL_LAST  = 6'd63;
    localparam logic [FillW-1:0] LEN_OFFSET = 6'd56;
    localparam logic [LenW-1:0]  LEN_LAST   = 3'd7;
    localparam logic [IdxW-1:0]  IDX_LAST   = 3'd4;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    localparam logic CMD_FEED   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
    } work_t;

    typedef struct packed {
        logic load;
        logic step;
    } buf_ctl_t;

endpackage

`default_nettype wire

// File: src/sha1sh_round.sv
// ============================================================================
// sha1sh_round
// One SHA-1 compression round; shared by all 80 rounds of a block.
// ============================================================================
`default_nettype none

module sha1sh_round (
    input  wire sha1sh_pkg::work_t  cur,
    input  wire sha1sh_pkg::word_t  w,
    input  wire sha1sh_pkg::round_t round,
    output sha1sh_pkg::work_t       nxt
);

    sha1sh_pkg::word_t f;
    sha1sh_pkg::word_t k;
    sha1sh_pkg::word_t t;

    always_comb begin
        priority if (round < sha1sh_pkg::ROUND_F1) begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = sha1sh_pkg::K0;
        end else if (round < sha1sh_pkg::ROUND_F2) begin
            f = cur.b ^ cur.c ^ cur.d;
            k = sha1sh_pkg::K1;
        end else if (round < sha1sh_pkg::ROUND_F3) begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = sha1sh_pkg::K2;
        end else begin
            f = cur.b ^ cur.c ^ cur.d;
            k = sha1sh_pkg::K3;
        end
    end

    assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

    always_comb begin
        nxt.a = t;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

`default_nettype wire

// File: src/sha1sh_msg_buf.sv
// ============================================================================
// sha1sh_msg_buf
// 64-byte block buffer; bytes shift in, then it runs as the 16-word schedule.
// ============================================================================
`default_nettype none

module sha1sh_msg_buf (
    input  wire logic                 aclk,
    input  wire sha1sh_pkg::buf_ctl_t ctl,
    input  wire logic [7:0]           byte_in,
    output sha1sh_pkg::word_t         w_out
);

    localparam int unsigned Top = sha1sh_pkg::BlockBits - 1;
    localparam int unsigned WW  = sha1sh_pkg::WordW;

    logic [sha1sh_pkg::BlockBits-1:0] blk_reg;
    sha1sh_pkg::word_t                mix;

    // window word j sits at blk_reg[Top - j*32 -: 32]
    assign w_out = blk_reg[Top -: WW];
    assign mix   = blk_reg[Top - 13*WW -: WW] ^ blk_reg[Top - 8*WW -: WW]
                 ^ blk_reg[Top - 2*WW -: WW]  ^ blk_reg[Top -: WW];

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            blk_reg <= {blk_reg[sha1sh_pkg::BlockBits-9:0], byte_in};
        end else if (ctl.step) begin
            blk_reg <= {blk_reg[sha1sh_pkg::BlockBits-WW-1:0], mix[30:0], mix[31]};
        end
    end

endmodule

`default_nettype wire

// File: src/sha1_stream_hasher.sv
// ============================================================================
// sha1_stream_hasher
// SHA-1 over a byte stream; finish transfer pads and emits five digest words.
// ============================================================================
//  channel | dir | tdata                          | tuser      | tlast
//  s_      | in  | data_byte[7:0]                 | command    | -
//  m_      | out | digest_word[31:0], word_index  | -          | last_word
//
//  Feed transfer: the 64th byte of a block starts its 80 rounds, then the fold.
//  Finish: accept, one push per pad byte (9 to 72), a step with no push ahead
//  of the length field, 80 rounds and a fold per block it completes (1 or 2),
//  then five output transfers.
//  One round unit runs one round per cycle; s_tready is low while busy.
//  m_ stalls hold the current word; aresetn restores the initial chain.
`default_nettype none

module sha1_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    state_t                               state_reg, state_next;
    state_t                               resume_reg, resume_next;
    logic [sha1sh_pkg::FillW-1:0]         fill_reg, fill_next;
    logic [sha1sh_pkg::MsgW-1:0]          msg_reg, msg_next;
    logic [sha1sh_pkg::LenW-1:0]          len_reg, len_next;
    sha1sh_pkg::round_t                   round_reg, round_next;
    logic [sha1sh_pkg::IdxW-1:0]          idx_reg, idx_next;
    sha1sh_pkg::word_t                    chain_reg [sha1sh_pkg::NumWords];
    sha1sh_pkg::word_t                    chain_next [sha1sh_pkg::NumWords];
    sha1sh_pkg::work_t                    work_reg, work_next;
    sha1sh_pkg::work_t                    round_out;
    sha1sh_pkg::word_t                    w_cur;
    sha1sh_pkg::buf_ctl_t                 buf_ctl;
    logic [7:0]                           push_byte;
    logic [7:0]                           len_byte;
    logic [31:0]                          len_bits;

    sha1sh_msg_buf u_msg_buf (
        .aclk    (aclk),
        .ctl     (buf_ctl),
        .byte_in (push_byte),
        .w_out   (w_cur)
    );

    sha1sh_round u_round (
        .cur   (work_reg),
        .w     (w_cur),
        .round (round_reg),
        .nxt   (round_out)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {5'b0, idx_reg, chain_reg[0]};
    assign m_tlast  = (idx_reg == sha1sh_pkg::IDX_LAST);

    assign len_bits = {msg_reg, 3'b000};

    always_comb begin
        if (!len_reg[2]) begin
            len_byte = 8'h00;
        end else begin
            unique case (len_reg[1:0])
                2'd0: len_byte = len_bits[31:24];
                2'd1: len_byte = len_bits[23:16];
                2'd2: len_byte = len_bits[15:8];
                2'd3: len_byte = len_bits[7:0];
            endcase
        end
    end

    always_comb begin
        logic push;
        push        = 1'b0;
        push_byte   = s_tdata;
        buf_ctl     = '0;
        state_next  = state_reg;
        resume_next = resume_reg;
        fill_next   = fill_reg;
        msg_next    = msg_reg;
        len_next    = len_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        work_next   = work_reg;
        chain_next  = chain_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == sha1sh_pkg::CMD_FEED) begin
                        push        = 1'b1;
                        msg_next    = msg_reg + 1'b1;
                        resume_next = ST_IDLE;
                    end else begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                push        = 1'b1;
                push_byte   = sha1sh_pkg::PAD_MARK_BYTE;
                state_next  = ST_PAD_ZERO;
                resume_next = ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (fill_reg == sha1sh_pkg::LEN_OFFSET) begin
                    state_next = ST_PAD_LEN;
                    len_next   = '0;
                end else begin
                    push        = 1'b1;
                    push_byte   = 8'h00;
                    resume_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN: begin
                push      = 1'b1;
                push_byte = len_byte;
                len_next  = len_reg + 1'b1;
                resume_next = (len_reg == sha1sh_pkg::LEN_LAST) ? ST_EMIT : ST_PAD_LEN;
            end
            ST_ROUND: begin
                buf_ctl.step = 1'b1;
                work_next    = round_out;
                round_next   = round_reg + 1'b1;
                if (round_reg == sha1sh_pkg::LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                state_next    = resume_reg;
                idx_next      = '0;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 1'b1;
                    for (int i = 0; i < sha1sh_pkg::NumWords - 1; i++) begin
                        chain_next[i] = chain_reg[i+1];
                    end
                    if (idx_reg == sha1sh_pkg::IDX_LAST) begin
                        chain_next = sha1sh_pkg::INIT_CHAIN;
                        msg_next   = '0;
                        fill_next  = '0;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (push) begin
            buf_ctl.load = 1'b1;
            fill_next    = fill_reg + 1'b1;
            if (fill_reg == sha1sh_pkg::FILL_LAST) begin
                state_next = ST_ROUND;
                round_next = '0;
                work_next  = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                               d: chain_reg[3], e: chain_reg[4]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            fill_reg   <= '0;
            msg_reg    <= '0;
            len_reg    <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            chain_reg  <= sha1sh_pkg::INIT_CHAIN;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            fill_reg   <= fill_next;
            msg_reg    <= msg_next;
            len_reg    <= len_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            chain_reg  <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest pending");

    a_round_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (fill_reg == '0))
        else $error("compression started on partial block");

    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == sha1sh_pkg::CMD_FINISH) |=> !s_tready)
        else $error("ready after finish transfer");

    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && msg_reg == '0))
        else $error("not idle after last digest word");

    a_emit_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (fill_reg == '0 && idx_reg == '0))
        else $error("digest emitted from partial state");
`endif

endmodule

`default_nettype wire
